// ===== rtl/motor_status_led_blinker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motor status LED blinker
// Shared macros for concurrent checks on the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_STATUS_LED_BLINKER_UNIT_ASSERT_SVH
`define MOTOR_STATUS_LED_BLINKER_UNIT_ASSERT_SVH

// check outside reset
`define MSLB_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mslb assertion failed");

// check at every edge, reset included
`define MSLB_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("mslb assertion failed");

`endif

// ===== rtl/mslb_pkg.sv =====
// ----------------------------------------------------------------------------
// mslb_pkg
// Opcodes, mode codes, LED patterns and defaults for the LED blinker.
// ----------------------------------------------------------------------------
`default_nettype none

package mslb_pkg;

   localparam int OP_BITS       = 3;
   localparam int STATE_BITS    = 2;
   localparam int CODE_BITS     = 32;
   localparam int INTERVAL_BITS = 16;

   localparam int ERROR_CODE_BITS_DEF = 32;
   localparam int COUNTER_BITS_DEF    = 16;

   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd100;

   typedef logic [OP_BITS-1:0]    op_type;
   typedef logic [STATE_BITS-1:0] led_type;
   typedef logic [STATE_BITS-1:0] mode_type;

   localparam op_type OP_TICK      = 3'd0;
   localparam op_type OP_SET_MOTOR = 3'd1;
   localparam op_type OP_SET_MODE  = 3'd2;
   localparam op_type OP_REPORT    = 3'd3;
   localparam op_type OP_CLEAR     = 3'd4;

   localparam mode_type MODE_NORMAL     = 2'd0;
   localparam mode_type MODE_ALTERNATE  = 2'd1;
   localparam mode_type MODE_CONCURRENT = 2'd2;
   localparam mode_type MODE_ERROR      = 2'd3;

   localparam led_type LED_OFF    = 2'd0;
   localparam led_type LED_FIRST  = 2'd1;
   localparam led_type LED_SECOND = 2'd2;
   localparam led_type LED_BOTH   = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/mslb_err_width.sv =====
// ----------------------------------------------------------------------------
// mslb_err_width
// Number of bits up to and including the highest set bit (at least one).
// ----------------------------------------------------------------------------
`default_nettype none

module mslb_err_width #(
   parameter int ERROR_CODE_BITS = mslb_pkg::ERROR_CODE_BITS_DEF,
   parameter int WIDTH_BITS      = $clog2(ERROR_CODE_BITS + 1)
) (
   input  wire logic [ERROR_CODE_BITS-1:0] code,
   output logic      [WIDTH_BITS-1:0]      width
);

   always_comb begin
      width = WIDTH_BITS'(1);
      for (int i = 0; i < ERROR_CODE_BITS; i++) begin
         if (code[i]) begin
            width = WIDTH_BITS'(i + 1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/motor_status_led_blinker_unit.sv =====
// ----------------------------------------------------------------------------
// motor_status_led_blinker_unit
// Two-LED status pattern generator for a motor driver: motor state display,
// alternate and concurrent blinking, and serial error code playback.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    op, motor_state, flash_mode, error_code
// rsp      out        rsp_valid/rsp_ready    led_pattern, active_mode
// csr      in         csr_valid/csr_ready    blink_interval
//
// One transaction per cycle while rsp is not stalled; each result is registered
// through the input register, then the state/result register.
// The state registers double as the result register and update only when
// the result slot is free, so a stalled rsp holds one request in the input
// register and then drops req_ready.
// Synchronous active-high reset initializes control and state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_status_led_blinker_unit_assert.svh"

module motor_status_led_blinker_unit #(
   parameter int ERROR_CODE_BITS = mslb_pkg::ERROR_CODE_BITS_DEF,
   parameter int COUNTER_BITS    = mslb_pkg::COUNTER_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [mslb_pkg::OP_BITS-1:0]        req_op,
   input  wire logic [mslb_pkg::STATE_BITS-1:0]     req_motor_state,
   input  wire logic [mslb_pkg::STATE_BITS-1:0]     req_flash_mode,
   input  wire logic [mslb_pkg::CODE_BITS-1:0]      req_error_code,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [mslb_pkg::STATE_BITS-1:0]     rsp_led_pattern,
   output logic      [mslb_pkg::STATE_BITS-1:0]     rsp_active_mode,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mslb_pkg::INTERVAL_BITS-1:0]  csr_blink_interval
);

   localparam int IDX_BITS   = (ERROR_CODE_BITS > 1) ? $clog2(ERROR_CODE_BITS) : 1;
   localparam int PHASE_BITS = IDX_BITS + 1;
   localparam int CMP_BITS   = PHASE_BITS + 1;
   localparam int WIDTH_BITS = $clog2(ERROR_CODE_BITS + 1);
   localparam int TICK_CMP_BITS =
      (COUNTER_BITS > mslb_pkg::INTERVAL_BITS) ? COUNTER_BITS : mslb_pkg::INTERVAL_BITS;

   // input register
   logic                           in_valid_ff, in_valid_in;
   mslb_pkg::op_type               in_op_ff;
   logic [mslb_pkg::STATE_BITS-1:0] in_ms_ff;
   mslb_pkg::mode_type             in_bm_ff;
   logic [ERROR_CODE_BITS-1:0]     in_code_ff;

   // state / result
   logic                           out_valid_ff, out_valid_in;
   logic [mslb_pkg::INTERVAL_BITS-1:0] interval_ff;
   logic [COUNTER_BITS-1:0]        tick_ff, tick_in;
   mslb_pkg::mode_type             mode_ff, mode_in;
   logic [mslb_pkg::STATE_BITS-1:0] motor_ff, motor_in;
   mslb_pkg::led_type              led_ff, led_in;
   logic [ERROR_CODE_BITS-1:0]     error_ff, error_in;
   logic [PHASE_BITS-1:0]          phase_ff, phase_in;
   logic [WIDTH_BITS-1:0]          width_ff, width_in;

   logic                           req_take;
   logic                           advance;
   logic [WIDTH_BITS-1:0]          code_width;
   logic [COUNTER_BITS-1:0]        tick_inc;
   logic                           fire;
   logic                           play;
   logic [PHASE_BITS-1:0]          play_phase;
   logic [WIDTH_BITS-1:0]          play_width;
   logic [ERROR_CODE_BITS-1:0]     play_code;
   mslb_pkg::led_type              play_led;
   logic [CMP_BITS-1:0]            play_next;
   logic [PHASE_BITS-1:0]          play_phase_next;
   mslb_pkg::led_type              alt_led;
   mslb_pkg::led_type              conc_led;

   function automatic logic error_ff_sel(input logic [ERROR_CODE_BITS-1:0] code,
                                         input logic [PHASE_BITS-1:0] phase);
      return code[phase[IDX_BITS:1]];
   endfunction

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid       = out_valid_ff;
   assign rsp_led_pattern = led_ff;
   assign rsp_active_mode = mode_ff;

   mslb_err_width #(
      .ERROR_CODE_BITS (ERROR_CODE_BITS),
      .WIDTH_BITS      (WIDTH_BITS)
   ) u_err_width (
      .code  (in_code_ff),
      .width (code_width)
   );

   assign tick_inc = tick_ff + COUNTER_BITS'(1);
   assign fire     = TICK_CMP_BITS'(tick_inc) >= TICK_CMP_BITS'(interval_ff);
   assign alt_led  = (led_ff == mslb_pkg::LED_FIRST) ? mslb_pkg::LED_SECOND
                                                     : mslb_pkg::LED_FIRST;
   assign conc_led = (led_ff == mslb_pkg::LED_OFF) ? mslb_pkg::LED_BOTH
                                                   : mslb_pkg::LED_OFF;

   // error playback step, from phase zero with the new width on a report
   always_comb begin
      if (in_op_ff == mslb_pkg::OP_REPORT) begin
         play_phase = '0;
         play_width = code_width;
         play_code  = in_code_ff;
      end else begin
         play_phase = phase_ff;
         play_width = width_ff;
         play_code  = error_ff;
      end
      if (play_phase == '0) begin
         play_led = mslb_pkg::LED_BOTH;
      end else if (!play_phase[0]) begin
         play_led = mslb_pkg::LED_OFF;
      end else if (error_ff_sel(play_code, play_phase)) begin
         play_led = mslb_pkg::LED_SECOND;
      end else begin
         play_led = mslb_pkg::LED_FIRST;
      end
      play_next = CMP_BITS'(play_phase) + CMP_BITS'(1);
      if (play_next >= CMP_BITS'({play_width, 1'b0})) begin
         play_phase_next = '0;
      end else begin
         play_phase_next = play_next[PHASE_BITS-1:0];
      end
   end

   always_comb begin
      tick_in  = tick_ff;
      mode_in  = mode_ff;
      motor_in = motor_ff;
      led_in   = led_ff;
      error_in = error_ff;
      phase_in = phase_ff;
      width_in = width_ff;
      play     = 1'b0;
      if (advance) begin
         case (in_op_ff)
            mslb_pkg::OP_TICK: begin
               tick_in = tick_inc;
               if (fire) begin
                  tick_in = '0;
                  case (mode_ff)
                     mslb_pkg::MODE_ALTERNATE:  led_in = alt_led;
                     mslb_pkg::MODE_CONCURRENT: led_in = conc_led;
                     mslb_pkg::MODE_ERROR:      play   = 1'b1;
                     default: ;
                  endcase
               end
            end
            mslb_pkg::OP_SET_MOTOR: begin
               motor_in = in_ms_ff;
               if (mode_ff != mslb_pkg::MODE_ERROR) begin
                  mode_in = mslb_pkg::MODE_NORMAL;
                  led_in  = in_ms_ff;
               end
            end
            mslb_pkg::OP_SET_MODE: begin
               if (in_bm_ff != mode_ff) begin
                  tick_in = '0;
                  mode_in = in_bm_ff;
                  if (in_bm_ff == mslb_pkg::MODE_ALTERNATE) begin
                     led_in = alt_led;
                  end else if (in_bm_ff == mslb_pkg::MODE_CONCURRENT) begin
                     led_in = conc_led;
                  end
               end
            end
            mslb_pkg::OP_REPORT: begin
               if (!(mode_ff == mslb_pkg::MODE_ERROR && error_ff == in_code_ff)) begin
                  mode_in  = mslb_pkg::MODE_ERROR;
                  error_in = in_code_ff;
                  width_in = code_width;
                  play     = 1'b1;
               end
            end
            mslb_pkg::OP_CLEAR: begin
               if (mode_ff == mslb_pkg::MODE_ERROR) begin
                  mode_in = mslb_pkg::MODE_NORMAL;
                  led_in  = motor_ff;
               end
            end
            default: ;
         endcase
         if (play) begin
            led_in   = play_led;
            phase_in = play_phase_next;
         end
      end
   end

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         interval_ff  <= mslb_pkg::INTERVAL_RESET;
         tick_ff      <= '0;
         mode_ff      <= mslb_pkg::MODE_NORMAL;
         motor_ff     <= '0;
         led_ff       <= mslb_pkg::LED_OFF;
         error_ff     <= '0;
         phase_ff     <= '0;
         width_ff     <= WIDTH_BITS'(1);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            interval_ff <= csr_blink_interval;
         end
         tick_ff  <= tick_in;
         mode_ff  <= mode_in;
         motor_ff <= motor_in;
         led_ff   <= led_in;
         error_ff <= error_in;
         phase_ff <= phase_in;
         width_ff <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_op;
         in_ms_ff   <= req_motor_state;
         in_bm_ff   <= req_flash_mode;
         in_code_ff <= req_error_code[ERROR_CODE_BITS-1:0];
      end
   end

   `MSLB_ASSERT(a_phase_bound, CMP_BITS'(phase_ff) < CMP_BITS'({width_ff, 1'b0}))
   `MSLB_ASSERT(a_stall_full, !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
   `MSLB_ASSERT(a_advance_result, advance |=> rsp_valid)
   `MSLB_ASSERT(a_motor_shown, (advance && in_op_ff == mslb_pkg::OP_SET_MOTOR &&
      mode_ff != mslb_pkg::MODE_ERROR) |=> (led_ff == $past(in_ms_ff)))

endmodule

`default_nettype wire
